FILE: rtl/core/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// shared widths, constants and sideband types of the swept box test core
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

   localparam int COORD_BITS     = 24;
   localparam int TIME_FRAC_BITS = 16;
   localparam int TIME_BITS      = 16;
   localparam int GAP_BITS       = COORD_BITS + 1;
   localparam int QUO_BITS       = TIME_FRAC_BITS + 1;
   localparam int REM_BITS       = GAP_BITS + QUO_BITS;
   localparam int DIV_STAGES     = QUO_BITS;

   // 0.016 s in Q0.16
   localparam logic [TIME_BITS-1:0] FRAME_TIME_RESET = 16'd1049;

   typedef struct packed {
      logic en_use;
      logic ex_use;
      logic fail;
      logic vzero;
   } axis_type;

   typedef struct packed {
      axis_type x;
      axis_type y;
      logic     still;
   } side_type;

endpackage

`default_nettype wire

FILE: rtl/core/sac_front.sv
// ----------------------------------------------------------------------------
// sac_front
// two register stages: bound differences, then axis cases and magnitudes
// ----------------------------------------------------------------------------
`default_nettype none

module sac_front (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  a_min_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  a_min_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  a_max_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  a_max_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  b_min_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  b_min_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  b_max_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  b_max_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  a_vel_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  a_vel_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  b_vel_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  b_vel_y,
   output      logic        [sac_pkg::GAP_BITS-1:0]    en_mag_x,
   output      logic        [sac_pkg::GAP_BITS-1:0]    ex_mag_x,
   output      logic        [sac_pkg::GAP_BITS-1:0]    vel_mag_x,
   output      logic        [sac_pkg::GAP_BITS-1:0]    en_mag_y,
   output      logic        [sac_pkg::GAP_BITS-1:0]    ex_mag_y,
   output      logic        [sac_pkg::GAP_BITS-1:0]    vel_mag_y,
   output      sac_pkg::side_type                      side
);

   localparam int GB = sac_pkg::GAP_BITS;

   // stage one: d1 = amax - bmin, d2 = amin - bmax, v = vb - va
   logic signed [GB-1:0] d1x_ff, d2x_ff, vx_ff, d1y_ff, d2y_ff, vy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d1x_ff <= GB'(a_max_x) - GB'(b_min_x);
         d2x_ff <= GB'(a_min_x) - GB'(b_max_x);
         vx_ff  <= GB'(b_vel_x) - GB'(a_vel_x);
         d1y_ff <= GB'(a_max_y) - GB'(b_min_y);
         d2y_ff <= GB'(a_min_y) - GB'(b_max_y);
         vy_ff  <= GB'(b_vel_y) - GB'(a_vel_y);
      end
   end

   function automatic logic [GB-1:0] mag_of(input logic [GB-1:0] v);
      return v[GB-1] ? (~v + GB'(1)) : v;
   endfunction

   // one axis worth of case logic
   function automatic sac_pkg::axis_type axis_of(input logic [GB-1:0] d1,
                                                 input logic [GB-1:0] d2,
                                                 input logic [GB-1:0] v);
      sac_pkg::axis_type a;
      logic lt, gt, neg, zero, pos;
      lt   = d1[GB-1];
      gt   = !d2[GB-1] && (d2 != '0);
      neg  = v[GB-1];
      zero = (v == '0);
      pos  = !neg && !zero;
      a.vzero  = zero;
      a.fail   = neg ? gt : (pos ? lt : (lt || gt));
      a.en_use = neg ? lt : (pos && gt);
      a.ex_use = neg ? d2[GB-1] : (pos && !d1[GB-1] && (d1 != '0));
      return a;
   endfunction

   sac_pkg::side_type side_in;

   always_comb begin
      side_in.x     = axis_of(d1x_ff, d2x_ff, vx_ff);
      side_in.y     = axis_of(d1y_ff, d2y_ff, vy_ff);
      side_in.still = !d1x_ff[GB-1] && !(!d2x_ff[GB-1] && d2x_ff != '0) &&
                      !d1y_ff[GB-1] && !(!d2y_ff[GB-1] && d2y_ff != '0);
   end

   // stage two: entry gap is d1 for a falling speed, d2 for a rising one
   always_ff @(posedge clock) begin
      if (en) begin
         en_mag_x  <= mag_of(vx_ff[GB-1] ? d1x_ff : d2x_ff);
         ex_mag_x  <= mag_of(vx_ff[GB-1] ? d2x_ff : d1x_ff);
         vel_mag_x <= mag_of(vx_ff);
         en_mag_y  <= mag_of(vy_ff[GB-1] ? d1y_ff : d2y_ff);
         ex_mag_y  <= mag_of(vy_ff[GB-1] ? d2y_ff : d1y_ff);
         vel_mag_y <= mag_of(vy_ff);
         side      <= side_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/sac_div.sv
// ----------------------------------------------------------------------------
// sac_div
// pipelined restoring divider, one quotient bit per stage, saturation flag
// ----------------------------------------------------------------------------
`default_nettype none

module sac_div (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [sac_pkg::GAP_BITS-1:0]    dividend,
   input  wire logic [sac_pkg::GAP_BITS-1:0]    divisor,
   output      logic [sac_pkg::QUO_BITS-1:0]    quo,
   output      logic                            sat
);

   localparam int RB = sac_pkg::REM_BITS;
   localparam int QB = sac_pkg::QUO_BITS;
   localparam int NS = sac_pkg::DIV_STAGES;

   logic [RB-1:0]                 r_ff   [0:NS];
   logic [sac_pkg::GAP_BITS-1:0]  v_ff   [0:NS];
   logic [QB-1:0]                 q_ff   [0:NS];
   logic                          sat_ff [0:NS];

   // quotient of 2^17 or more: gap at least twice the speed
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= RB'(dividend) << sac_pkg::TIME_FRAC_BITS;
         v_ff[0]   <= divisor;
         q_ff[0]   <= '0;
         sat_ff[0] <= {1'b0, dividend} >= {divisor, 1'b0};
      end
   end

   for (genvar g = 1; g <= NS; g++) begin : g_stage
      localparam int SH = NS - g;
      logic [RB-1:0] vs;
      logic          geq;
      assign vs  = RB'(v_ff[g-1]) << SH;
      assign geq = r_ff[g-1] >= vs;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[g]   <= geq ? (r_ff[g-1] - vs) : r_ff[g-1];
            v_ff[g]   <= v_ff[g-1];
            q_ff[g]   <= q_ff[g-1] | (geq ? (QB'(1) << SH) : '0);
            sat_ff[g] <= sat_ff[g-1];
         end
      end
   end

   assign quo = q_ff[NS];
   assign sat = sat_ff[NS];

endmodule

`default_nettype wire

FILE: rtl/core/sac_back.sv
// ----------------------------------------------------------------------------
// sac_back
// clamps the four times and folds them into the entry and exit window
// ----------------------------------------------------------------------------
`default_nettype none

module sac_back (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic [sac_pkg::TIME_BITS-1:0]    frame_time,
   input  wire logic [sac_pkg::QUO_BITS-1:0]     q_en_x,
   input  wire logic                             s_en_x,
   input  wire logic [sac_pkg::QUO_BITS-1:0]     q_ex_x,
   input  wire logic                             s_ex_x,
   input  wire logic [sac_pkg::QUO_BITS-1:0]     q_en_y,
   input  wire logic                             s_en_y,
   input  wire logic [sac_pkg::QUO_BITS-1:0]     q_ex_y,
   input  wire logic                             s_ex_y,
   input  wire sac_pkg::side_type                side,
   output      logic [sac_pkg::QUO_BITS-1:0]     t_in,
   output      logic [sac_pkg::QUO_BITS-1:0]     t_out,
   output      logic                             still,
   output      logic                             no_sweep
);

   localparam int QB = sac_pkg::QUO_BITS;

   logic [QB-1:0] cap, te_x, tx_x, te_y, tx_y, tin_in, tout_in;

   function automatic logic [QB-1:0] clamp(input logic [QB-1:0] q, input logic s,
                                           input logic [QB-1:0] c);
      return (s || q > c) ? c : q;
   endfunction

   always_comb begin
      cap     = QB'(frame_time) + QB'(1);
      te_x    = side.x.en_use ? clamp(q_en_x, s_en_x, cap) : '0;
      te_y    = side.y.en_use ? clamp(q_en_y, s_en_y, cap) : '0;
      tx_x    = side.x.ex_use ? clamp(q_ex_x, s_ex_x, cap) : cap;
      tx_y    = side.y.ex_use ? clamp(q_ex_y, s_ex_y, cap) : cap;
      tin_in  = (te_x > te_y) ? te_x : te_y;
      tout_in = (tx_x < tx_y) ? tx_x : tx_y;
      if (QB'(frame_time) < tout_in) begin
         tout_in = QB'(frame_time);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_in     <= tin_in;
         t_out    <= tout_in;
         still    <= side.still;
         no_sweep <= side.x.fail || side.y.fail || (side.x.vzero && side.y.vzero);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/swept_aabb_collision_test_core.sv
// ----------------------------------------------------------------------------
// swept_aabb_collision_test_core
// 2d swept box pair test: static overlap, then per-axis entry/exit window
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | box bounds and velocities
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_hit, rsp_overlap_now
//  csr     | in        | csr_valid / csr_ready  | csr_frame_time
//
//  one item a cycle while the output item is not held; the pipe is the 17
//  quotient stages of the four dividers plus two front stages, the divider
//  input stage, one fold stage and the output register
//  reset clears the valid bits and loads frame_time with 0.016 s
//  a held result stalls every stage at once; nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module swept_aabb_collision_test_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_a_min_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_a_min_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_a_max_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_a_max_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_b_min_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_b_min_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_b_max_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_b_max_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_a_vel_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_a_vel_y,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_b_vel_x,
   input  wire logic signed [sac_pkg::COORD_BITS-1:0]  req_b_vel_y,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      logic                                   rsp_hit,
   output      logic                                   rsp_overlap_now,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [sac_pkg::TIME_BITS-1:0]          csr_frame_time
);

   localparam int NS    = sac_pkg::DIV_STAGES;
   // two front stages, divider input stage plus quotient stages, fold stage
   localparam int DEPTH = 2 + NS + 1 + 1;

   logic advance;
   logic [sac_pkg::TIME_BITS-1:0] frame_time_ff;
   logic valid_ff [0:DEPTH-1];
   logic rsp_valid_ff, rsp_hit_ff, rsp_overlap_now_ff;

   // whole pipe moves together unless the output item is held
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= sac_pkg::FRAME_TIME_RESET;
      end else if (csr_valid) begin
         frame_time_ff <= csr_frame_time;
      end
   end

   // valid bits travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) valid_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
         rsp_valid_ff <= valid_ff[DEPTH-1];
      end
   end

   // front: differences, axis cases, magnitudes
   logic [sac_pkg::GAP_BITS-1:0] en_mag_x, ex_mag_x, vel_mag_x;
   logic [sac_pkg::GAP_BITS-1:0] en_mag_y, ex_mag_y, vel_mag_y;
   sac_pkg::side_type side_front;

   sac_front u_front (
      .clock     (clock),
      .en        (advance),
      .a_min_x   (req_a_min_x),
      .a_min_y   (req_a_min_y),
      .a_max_x   (req_a_max_x),
      .a_max_y   (req_a_max_y),
      .b_min_x   (req_b_min_x),
      .b_min_y   (req_b_min_y),
      .b_max_x   (req_b_max_x),
      .b_max_y   (req_b_max_y),
      .a_vel_x   (req_a_vel_x),
      .a_vel_y   (req_a_vel_y),
      .b_vel_x   (req_b_vel_x),
      .b_vel_y   (req_b_vel_y),
      .en_mag_x  (en_mag_x),
      .ex_mag_x  (ex_mag_x),
      .vel_mag_x (vel_mag_x),
      .en_mag_y  (en_mag_y),
      .ex_mag_y  (ex_mag_y),
      .vel_mag_y (vel_mag_y),
      .side      (side_front)
   );

   // sideband delay matching the divider depth
   sac_pkg::side_type side_ff [0:NS];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_front;
         for (int i = 1; i <= NS; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // four dividers: entry and exit time on each axis
   logic [sac_pkg::QUO_BITS-1:0] q_en_x, q_ex_x, q_en_y, q_ex_y;
   logic s_en_x, s_ex_x, s_en_y, s_ex_y;

   sac_div u_div_en_x (.clock(clock), .en(advance), .dividend(en_mag_x),
                       .divisor(vel_mag_x), .quo(q_en_x), .sat(s_en_x));
   sac_div u_div_ex_x (.clock(clock), .en(advance), .dividend(ex_mag_x),
                       .divisor(vel_mag_x), .quo(q_ex_x), .sat(s_ex_x));
   sac_div u_div_en_y (.clock(clock), .en(advance), .dividend(en_mag_y),
                       .divisor(vel_mag_y), .quo(q_en_y), .sat(s_en_y));
   sac_div u_div_ex_y (.clock(clock), .en(advance), .dividend(ex_mag_y),
                       .divisor(vel_mag_y), .quo(q_ex_y), .sat(s_ex_y));

   // fold into the window; the window only narrows, so one final check will do
   logic [sac_pkg::QUO_BITS-1:0] t_in, t_out;
   logic still, no_sweep;

   sac_back u_back (
      .clock      (clock),
      .en         (advance),
      .frame_time (frame_time_ff),
      .q_en_x     (q_en_x),
      .s_en_x     (s_en_x),
      .q_ex_x     (q_ex_x),
      .s_ex_x     (s_ex_x),
      .q_en_y     (q_en_y),
      .s_en_y     (s_en_y),
      .q_ex_y     (q_ex_y),
      .s_ex_y     (s_ex_y),
      .side       (side_ff[NS]),
      .t_in       (t_in),
      .t_out      (t_out),
      .still      (still),
      .no_sweep   (no_sweep)
   );

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff         <= still || (!no_sweep && (t_in <= t_out));
         rsp_overlap_now_ff <= still;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_overlap_now = rsp_overlap_now_ff;

   // a static overlap is always a hit
   a_overlap_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_overlap_now_ff |-> rsp_hit_ff)
      else $error("overlap item without hit");

   // a stall freezes the first and last valid bits inside the pipe
   a_stall_valid : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff[DEPTH-1]) && $stable(valid_ff[0]))
      else $error("valid bit moved during stall");

   // a stall freezes the x entry and y exit divider outputs
   a_stall_div : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(q_en_x) && $stable(q_ex_y))
      else $error("divider moved during stall");

endmodule

`default_nettype wire
